// ===== hdl/gng_pkg.sv =====
// ----------------------------------------------------------------------------
// Gaussian noise generator package
// Shared types, constants and helper functions for the noise generator.
// ----------------------------------------------------------------------------
package gng_pkg;

    // Fraction bits of the signed 16-bit result samples.
    localparam int OUTPUT_FRAC_BITS = 12;
    // Right shift that turns radius (Q25) times trig (Q30) into the result.
    localparam int OUT_SHIFT = 55 - OUTPUT_FRAC_BITS;
    localparam logic signed [61:0] ROUND_CONST = 62'sd1 <<< (OUT_SHIFT - 1);

    localparam logic [27:0] LN2_Q28         = 28'd186065279;
    localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;
    localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
    localparam logic [34:0] LOG2_FULL_Q30   = 35'd23 << 30;
    localparam logic [62:0] LN_ROUND        = 63'd1 << 26;

    localparam int CORDIC_STEPS = 30;
    localparam int LOG_STEPS    = 30;
    localparam int SQRT_STEPS   = 28;

    // Uniform fractions drawn from one generator step.
    typedef struct packed {
        logic [22:0] m0;
        logic [22:0] m1;
    } gng_item_t;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } gng_quad_t;

    // Arctangent of 2^-i in Q30.
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] val;
        begin
            case (idx)
                5'd0:  val = 30'h3243F6A8;
                5'd1:  val = 30'h1DAC6705;
                5'd2:  val = 30'h0FADBAFC;
                5'd3:  val = 30'h07F56EA6;
                5'd4:  val = 30'h03FEAB76;
                5'd5:  val = 30'h01FFD55B;
                5'd6:  val = 30'h00FFFAAA;
                5'd7:  val = 30'h007FFF55;
                5'd8:  val = 30'h003FFFEA;
                5'd9:  val = 30'h001FFFFD;
                5'd10: val = 30'h000FFFFF;
                5'd11: val = 30'h0007FFFF;
                5'd12: val = 30'h0003FFFF;
                5'd13: val = 30'h0001FFFF;
                5'd14: val = 30'h0000FFFF;
                5'd15: val = 30'h00007FFF;
                5'd16: val = 30'h00003FFF;
                5'd17: val = 30'h00001FFF;
                5'd18: val = 30'h00000FFF;
                5'd19: val = 30'h000007FF;
                5'd20: val = 30'h000003FF;
                5'd21: val = 30'h000001FF;
                5'd22: val = 30'h000000FF;
                5'd23: val = 30'h0000007F;
                5'd24: val = 30'h0000003F;
                5'd25: val = 30'h0000001F;
                5'd26: val = 30'h0000000F;
                5'd27: val = 30'h00000008;
                5'd28: val = 30'h00000004;
                5'd29: val = 30'h00000002;
                default: val = 30'h0;
            endcase
            return val;
        end
    endfunction

    // Round a Q55 product to the output scale and clamp to 16-bit signed.
    function automatic logic signed [15:0] round_sat(input logic signed [61:0] prod);
        logic signed [61:0] sum;
        logic signed [61:0] shifted;
        logic signed [15:0] res;
        begin
            sum     = prod + ROUND_CONST;
            shifted = sum >>> OUT_SHIFT;
            if (shifted > 62'sd32767) begin
                res = 16'sh7FFF;
            end else if (shifted < -62'sd32768) begin
                res = 16'sh8000;
            end else begin
                res = shifted[15:0];
            end
            return res;
        end
    endfunction

endpackage

// ===== hdl/gng_fifo.sv =====
// ----------------------------------------------------------------------------
// Gaussian noise generator item queue
// Two-entry queue that decouples the generator front end from the math unit.
// ----------------------------------------------------------------------------
module gng_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  gng_pkg::gng_item_t wr_item,
    output logic               full,
    input  logic               rd_en,
    output gng_pkg::gng_item_t rd_item,
    output logic               empty
);

    gng_pkg::gng_item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_item = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_en) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (wr_en && !rd_en) begin
                count_reg <= count_reg + 2'd1;
            end else if (rd_en && !wr_en) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== hdl/gng_front.sv =====
// ----------------------------------------------------------------------------
// Gaussian noise generator front end
// Seed registers and the xoroshiro128+ state; one draw per accepted request.
// ----------------------------------------------------------------------------
module gng_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               draw,
    input  logic               restart,
    output gng_pkg::gng_item_t item
);

    logic [63:0] seed_lo_reg;
    logic [63:0] seed_hi_reg;
    logic [63:0] word_a_reg;
    logic [63:0] word_b_reg;
    logic [63:0] s0;
    logic [63:0] s1;
    logic [63:0] sum;
    logic [63:0] mix;
    logic [63:0] word_a_next;
    logic [63:0] word_b_next;

    always_comb begin
        s0          = restart ? seed_lo_reg : word_a_reg;
        s1          = restart ? seed_hi_reg : word_b_reg;
        sum         = s0 + s1;
        mix         = s0 ^ s1;
        word_a_next = {s0[8:0], s0[63:9]} ^ mix ^ (mix << 14);
        word_b_next = {mix[27:0], mix[63:28]};
        item.m0     = sum[22:0];
        item.m1     = sum[54:32];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            seed_lo_reg <= 64'd1;
            seed_hi_reg <= 64'd0;
            word_a_reg  <= 64'd1;
            word_b_reg  <= 64'd0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index) begin
                    seed_hi_reg <= cfg_data;
                end else begin
                    seed_lo_reg <= cfg_data;
                end
            end
            if (draw) begin
                word_a_reg <= word_a_next;
                word_b_reg <= word_b_next;
            end
        end
    end

endmodule

// ===== hdl/gng_back.sv =====
// ----------------------------------------------------------------------------
// Gaussian noise generator math unit
// Sequential Box-Muller: log2, scaling, square root, CORDIC, output rounding.
// ----------------------------------------------------------------------------
module gng_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  gng_pkg::gng_item_t        q_item,
    output logic                      q_pop,
    input  logic                      pop,
    output logic                      empty,
    output logic signed [15:0]        gauss_sin,
    output logic signed [15:0]        gauss_cos
);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_LOG_SQ  = 13'b0000000000010,
        S_LOG_NRM = 13'b0000000000100,
        S_LN_LO   = 13'b0000000001000,
        S_LN_HI   = 13'b0000000010000,
        S_LN_SUM  = 13'b0000000100000,
        S_SQRT    = 13'b0000001000000,
        S_THETA   = 13'b0000010000000,
        S_CORDIC  = 13'b0000100000000,
        S_MUL_S   = 13'b0001000000000,
        S_MUL_C   = 13'b0010000000000,
        S_RND_C   = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } gng_state_t;

    gng_state_t state_reg;
    logic [4:0]  cnt_reg;
    logic [22:0] m1_reg;
    logic [4:0]  e_reg;
    logic [31:0] z_reg;
    logic [29:0] frac_reg;
    logic [63:0] sq_reg;
    logic [45:0] lo_reg;
    logic [44:0] hi_reg;
    logic [55:0] xs_reg;
    logic [30:0] rem_reg;
    logic [27:0] root_reg;
    logic signed [32:0] cx_reg;
    logic signed [32:0] cy_reg;
    logic signed [32:0] cz_reg;
    logic signed [61:0] prod_reg;
    logic signed [15:0] res_s_reg;
    logic signed [15:0] res_c_reg;
    logic        out_valid_reg;
    logic signed [15:0] out_sin_reg;
    logic signed [15:0] out_cos_reg;

    logic [23:0] n_val;
    logic [4:0]  e_val;
    logic [32:0] zt;
    logic [34:0] v_val;
    logic [62:0] ln_sum;
    logic [30:0] rem_sh;
    logic [30:0] trial;
    logic [51:0] ang;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] atan_s;
    logic signed [32:0] ssel;
    logic signed [32:0] csel;
    logic signed [28:0] radius_s;
    logic        out_load;

    assign empty     = !out_valid_reg;
    assign gauss_sin = out_sin_reg;
    assign gauss_cos = out_cos_reg;
    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || pop);

    always_comb begin
        n_val = {1'b0, q_item.m0} + 24'd1;
        e_val = 5'd0;
        for (int i = 1; i < 24; i++) begin
            if (n_val[i]) begin
                e_val = 5'(i);
            end
        end
        zt       = sq_reg[63:31];
        v_val    = gng_pkg::LOG2_FULL_Q30 - ({e_reg, 30'b0} + {5'b0, frac_reg});
        ln_sum   = {hi_reg, 18'b0} + {17'b0, lo_reg} + gng_pkg::LN_ROUND;
        rem_sh   = {rem_reg[28:0], xs_reg[55:54]};
        trial    = {1'b0, root_reg, 2'b01};
        ang      = m1_reg[20:0] * gng_pkg::HALF_PI_Q30;
        dx       = cy_reg >>> cnt_reg;
        dy       = cx_reg >>> cnt_reg;
        atan_s   = $signed({3'b0, gng_pkg::atan_q30(cnt_reg)});
        radius_s = $signed({1'b0, root_reg});
        unique case (gng_pkg::gng_quad_t'(m1_reg[22:21]))
            gng_pkg::QUAD_0: begin ssel = cy_reg;  csel = cx_reg;  end
            gng_pkg::QUAD_1: begin ssel = cx_reg;  csel = -cy_reg; end
            gng_pkg::QUAD_2: begin ssel = -cy_reg; csel = -cx_reg; end
            gng_pkg::QUAD_3: begin ssel = -cx_reg; csel = cy_reg;  end
            default:         begin ssel = cy_reg;  csel = cx_reg;  end
        endcase
    end

    // Datapath registers.
    always_ff @(posedge clk) begin
        unique case (state_reg)
            S_IDLE: begin
                m1_reg   <= q_item.m1;
                e_reg    <= e_val;
                z_reg    <= 32'({8'b0, n_val} << (5'd31 - e_val));
                frac_reg <= '0;
            end
            S_LOG_SQ: begin
                sq_reg <= z_reg * z_reg;
            end
            S_LOG_NRM: begin
                z_reg    <= zt[32] ? zt[32:1] : zt[31:0];
                frac_reg <= {frac_reg[28:0], zt[32]};
            end
            S_LN_LO: begin
                lo_reg <= v_val[17:0] * gng_pkg::LN2_Q28;
            end
            S_LN_HI: begin
                hi_reg <= v_val[34:18] * gng_pkg::LN2_Q28;
            end
            S_LN_SUM: begin
                xs_reg   <= {ln_sum[62:27], 20'b0};
                rem_reg  <= '0;
                root_reg <= '0;
            end
            S_SQRT: begin
                xs_reg <= {xs_reg[53:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[26:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[26:0], 1'b0};
                end
            end
            S_THETA: begin
                cz_reg <= $signed({2'b0, ang[51:21]});
                cx_reg <= gng_pkg::CORDIC_GAIN_Q30;
                cy_reg <= '0;
            end
            S_CORDIC: begin
                if (!cz_reg[32]) begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    cz_reg <= cz_reg - atan_s;
                end else begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    cz_reg <= cz_reg + atan_s;
                end
            end
            S_MUL_S: begin
                prod_reg <= radius_s * ssel;
            end
            S_MUL_C: begin
                res_s_reg <= gng_pkg::round_sat(prod_reg);
                prod_reg  <= radius_s * csel;
            end
            S_RND_C: begin
                res_c_reg <= gng_pkg::round_sat(prod_reg);
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Output samples, loaded when the finished pair moves out.
    always_ff @(posedge clk) begin
        if (out_load) begin
            out_sin_reg <= res_s_reg;
            out_cos_reg <= res_c_reg;
        end
    end

    // Control: sequencer and output valid.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    cnt_reg <= '0;
                    if (!q_empty) begin
                        state_reg <= S_LOG_SQ;
                    end
                end
                S_LOG_SQ: begin
                    state_reg <= S_LOG_NRM;
                end
                S_LOG_NRM: begin
                    if (cnt_reg == 5'(gng_pkg::LOG_STEPS - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= S_LN_LO;
                    end else begin
                        cnt_reg   <= cnt_reg + 5'd1;
                        state_reg <= S_LOG_SQ;
                    end
                end
                S_LN_LO: begin
                    state_reg <= S_LN_HI;
                end
                S_LN_HI: begin
                    state_reg <= S_LN_SUM;
                end
                S_LN_SUM: begin
                    cnt_reg   <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT: begin
                    if (cnt_reg == 5'(gng_pkg::SQRT_STEPS - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= S_THETA;
                    end else begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_THETA: begin
                    cnt_reg   <= '0;
                    state_reg <= S_CORDIC;
                end
                S_CORDIC: begin
                    if (cnt_reg == 5'(gng_pkg::CORDIC_STEPS - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= S_MUL_S;
                    end else begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_MUL_S: begin
                    state_reg <= S_MUL_C;
                end
                S_MUL_C: begin
                    state_reg <= S_RND_C;
                end
                S_RND_C: begin
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/gaussian_noise_generator.sv =====
// ----------------------------------------------------------------------------
// Gaussian noise generator
// xoroshiro128+ uniform source feeding a fixed-point Box-Muller transform.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                  Payload
//   --------  -------------------------  ---------------------------------
//   request   push / full                restart
//   result    empty / pop                gauss_sin, gauss_cos (Q3.12)
//   config    cfg_valid / cfg_ready      cfg_index, cfg_data (64-bit seed)
//
// A request transaction advances the generator in the same cycle and queues
// the two uniform fractions in a two-entry queue. The math unit then runs
// the 30 squaring steps of log2, the bit-serial square root, the CORDIC
// rotations and the scaling, setup and rounding states. It takes one item
// at a time and pops the next only after the finished pair moves out, so
// it sets the sustained rate. A finished pair waits in the output register;
// the math unit stalls in its final state while that register is still
// full, and full rises once the queue holds two items. Reset loads seed
// words 1 and 0 and the same generator state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module gaussian_noise_generator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               restart,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] gauss_sin,
    output logic signed [15:0] gauss_cos,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [63:0]        cfg_data
);

    gng_pkg::gng_item_t front_item;
    gng_pkg::gng_item_t queue_item;
    logic               queue_full;
    logic               queue_empty;
    logic               queue_pop;
    logic               draw;

    // Always ready; user changes configuration only while idle, not enforced.
    assign cfg_ready = 1'b1;
    assign full      = queue_full;
    // A request transaction advances the generator and fills one queue slot.
    assign draw      = push && !queue_full;

    gng_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .draw      (draw),
        .restart   (restart),
        .item      (front_item)
    );

    gng_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (draw),
        .wr_item (front_item),
        .full    (queue_full),
        .rd_en   (queue_pop),
        .rd_item (queue_item),
        .empty   (queue_empty)
    );

    gng_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (queue_empty),
        .q_item    (queue_item),
        .q_pop     (queue_pop),
        .pop       (pop),
        .empty     (empty),
        .gauss_sin (gauss_sin),
        .gauss_cos (gauss_cos)
    );

endmodule
